FILE: sv/lpwd_pkg.sv
package lpwd_pkg;

  // command codes carried with each request
  typedef enum logic {
    CMD_DATA  = 1'b0,
    CMD_CLOSE = 1'b1
  } command_t;

  // result event codes
  typedef enum logic [1:0] {
    EV_WORD     = 2'd0,
    EV_END      = 2'd1,
    EV_ABORT    = 2'd2,
    EV_OVERFLOW = 2'd3
  } event_kind_t;

  localparam int unsigned INDEX_W = 11;

  // one received request
  typedef struct packed {
    command_t    command;
    logic [7:0]  data_byte;
  } item_t;

  // one result request
  typedef struct packed {
    event_kind_t          event_kind;
    logic [31:0]          payload_word;
    logic [INDEX_W-1:0]   word_index;
    logic                 block_last;
  } result_t;

  // result handed from the parser to the output register
  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

FILE: sv/lpwd_in_stage.sv
module lpwd_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  lpwd_pkg::item_t item,
  input  logic           take,
  output logic           held_valid,
  output lpwd_pkg::item_t held_item
);

  logic load;

  // accept whenever the held request is empty or leaving this cycle
  assign item_ready = !held_valid || take;
  assign load       = item_valid && item_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // held request payload
  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= item;
    end
  end

endmodule

FILE: sv/lpwd_parser.sv
module lpwd_parser #(
  parameter int unsigned MAX_WORDS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            held_valid,
  input  lpwd_pkg::item_t held_item,
  input  logic            out_free,
  output logic            take,
  output lpwd_pkg::push_t push
);

  localparam int unsigned CNT_W = $clog2(MAX_WORDS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WORDS);

  logic             in_payload, in_payload_next;
  logic [1:0]       byte_phase, byte_phase_next;
  logic [31:0]      shift_assembly, shift_assembly_next;
  logic [31:0]      words_left, words_left_next;
  logic [CNT_W-1:0] word_total, word_total_next;

  logic             has_res;
  lpwd_pkg::result_t res;
  logic [7:0]       b;
  logic [31:0]      wl_dec;

  assign b      = held_item.data_byte;
  assign wl_dec = words_left - 32'd1;

  // per-byte step: next state and result
  always_comb begin
    in_payload_next     = in_payload;
    byte_phase_next     = byte_phase + 2'd1;
    shift_assembly_next = shift_assembly;
    words_left_next     = words_left;
    word_total_next     = word_total;
    has_res             = 1'b0;
    res                 = '0;
    res.event_kind      = lpwd_pkg::EV_WORD;

    if (held_item.command == lpwd_pkg::CMD_CLOSE) begin
      // close: back to reset state, report abort
      in_payload_next     = 1'b0;
      byte_phase_next     = 2'd0;
      shift_assembly_next = '0;
      words_left_next     = '0;
      word_total_next     = '0;
      has_res             = 1'b1;
      res.event_kind      = lpwd_pkg::EV_ABORT;
    end else if (!in_payload) begin
      // header, big-endian count
      if (byte_phase == 2'd0) begin
        shift_assembly_next = {24'd0, b};
      end else begin
        shift_assembly_next = {shift_assembly[23:0], b};
      end
      if (byte_phase == 2'd3) begin
        if (shift_assembly_next == 32'd0) begin
          has_res         = 1'b1;
          res.event_kind  = lpwd_pkg::EV_END;
          res.word_index  = lpwd_pkg::INDEX_W'(word_total);
          word_total_next = '0;
        end else begin
          words_left_next = shift_assembly_next;
          in_payload_next = 1'b1;
        end
      end
    end else begin
      // payload, little-endian word
      unique case (byte_phase)
        2'd0: shift_assembly_next = {24'd0, b};
        2'd1: shift_assembly_next = {shift_assembly[31:16], b, shift_assembly[7:0]};
        2'd2: shift_assembly_next = {shift_assembly[31:24], b, shift_assembly[15:0]};
        2'd3: shift_assembly_next = {b, shift_assembly[23:0]};
        default: shift_assembly_next = shift_assembly;
      endcase
      if (byte_phase == 2'd3) begin
        words_left_next  = wl_dec;
        has_res          = 1'b1;
        res.payload_word = shift_assembly_next;
        res.word_index   = lpwd_pkg::INDEX_W'(word_total);
        res.block_last   = (wl_dec == 32'd0);
        if (wl_dec == 32'd0) begin
          in_payload_next = 1'b0;
        end
        if (word_total < MAX_CNT) begin
          res.event_kind  = lpwd_pkg::EV_WORD;
          word_total_next = word_total + CNT_W'(1);
        end else begin
          res.event_kind  = lpwd_pkg::EV_OVERFLOW;
        end
      end
    end
  end

  // a byte without a result never waits for the output side
  assign take       = held_valid && (!has_res || out_free);
  assign push.valid = take && has_res;
  assign push.res   = res;

  // parser control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload <= 1'b0;
      byte_phase <= 2'd0;
      words_left <= '0;
      word_total <= '0;
    end else if (take) begin
      in_payload <= in_payload_next;
      byte_phase <= byte_phase_next;
      words_left <= words_left_next;
      word_total <= word_total_next;
    end
  end

  // group being assembled
  always_ff @(posedge clk) begin
    if (take) begin
      shift_assembly <= shift_assembly_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_close_resets: assert property (@(posedge clk) disable iff (rst)
    (take && held_item.command == lpwd_pkg::CMD_CLOSE)
      |=> (!in_payload && byte_phase == 2'd0 && word_total == '0))
    else $error("close did not reset the parser");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    word_total <= MAX_CNT)
    else $error("word total above limit");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (words_left != 32'd0))
    else $error("inside a block with no words left");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (push.valid && push.res.event_kind == lpwd_pkg::EV_OVERFLOW)
      |-> (word_total == MAX_CNT))
    else $error("overflow reported below limit");
`endif

endmodule

FILE: sv/lpwd_out_stage.sv
module lpwd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  lpwd_pkg::push_t   push,
  output logic              out_free,
  output logic              result_valid,
  input  logic              result_ready,
  output lpwd_pkg::result_t result
);

  // room when empty or being drained this cycle
  assign out_free = !result_valid || result_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push.valid) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (push.valid) begin
      result <= push.res;
    end
  end

endmodule

FILE: sv/length_prefixed_word_deframer.sv
// each byte is held in the input register; its result goes to the result register
// throughput: one request per cycle sustained; a byte that completes a result waits
// only while the result register is full and not being drained
// the rate is set by the single combinational parse step between input and result registers
// reset: synchronous rst empties both registers and returns the parser to header mode
module length_prefixed_word_deframer #(
  parameter int unsigned MAX_WORDS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  lpwd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output lpwd_pkg::result_t result
);

  logic            held_valid;
  lpwd_pkg::item_t held_item;
  logic            take;
  logic            out_free;
  lpwd_pkg::push_t push;

  // input register
  lpwd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // header and word parsing
  lpwd_parser #(
    .MAX_WORDS (MAX_WORDS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_item  (held_item),
    .out_free   (out_free),
    .take       (take),
    .push       (push)
  );

  // result register
  lpwd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .out_free     (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

FILE: test/length_prefixed_word_deframer_tb.sv
`timescale 1ns / 1ps

module length_prefixed_word_deframer_tb;

  localparam int unsigned MAX_WORDS = 1024;
  localparam int unsigned QUIET_LIMIT = 2000;

  // one row of the directed stimulus table
  typedef struct {
    lpwd_pkg::item_t   it;
    bit                typed;
    lpwd_pkg::result_t want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  lpwd_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  lpwd_pkg::result_t result;

  // results still owed by the block, oldest first
  lpwd_pkg::result_t due_results[$];
  row_t              plan[$];

  int unsigned send_gap_pct = 24;
  int unsigned recv_stall_pct = 74;
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // deframer state as predicted
  bit          in_block = 1'b0;
  logic [1:0]  grp_phase = 2'd0;
  logic [31:0] grp_acc = '0;
  logic [31:0] words_due = '0;
  int unsigned kept_words = 0;

  length_prefixed_word_deframer #(
    .MAX_WORDS(MAX_WORDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always #10 clk = ~clk;

  // predicted effect of one accepted request on the parser
  task automatic deframe_step(input lpwd_pkg::item_t it, output bit fired,
                              output lpwd_pkg::result_t res);
    logic [1:0] ph;
    ph = grp_phase;
    fired = 1'b0;
    res = '0;
    if (it.command == lpwd_pkg::CMD_CLOSE) begin
      in_block = 1'b0;
      grp_phase = 2'd0;
      grp_acc = '0;
      words_due = '0;
      kept_words = 0;
      fired = 1'b1;
      res.event_kind = lpwd_pkg::EV_ABORT;
    end else if (!in_block) begin
      // header count, most significant byte first
      grp_acc = (ph == 2'd0) ? {24'd0, it.data_byte} : {grp_acc[23:0], it.data_byte};
      grp_phase = ph + 2'd1;
      if (ph == 2'd3) begin
        if (grp_acc == '0) begin
          fired = 1'b1;
          res.event_kind = lpwd_pkg::EV_END;
          res.word_index = kept_words[lpwd_pkg::INDEX_W-1:0];
          kept_words = 0;
        end else begin
          words_due = grp_acc;
          in_block = 1'b1;
        end
      end
    end else begin
      // payload word, least significant byte first
      if (ph == 2'd0)
        grp_acc = {24'd0, it.data_byte};
      else
        grp_acc = grp_acc | ({24'd0, it.data_byte} << (8 * ph));
      grp_phase = ph + 2'd1;
      if (ph == 2'd3) begin
        words_due = words_due - 32'd1;
        fired = 1'b1;
        res.payload_word = grp_acc;
        res.word_index = kept_words[lpwd_pkg::INDEX_W-1:0];
        res.block_last = (words_due == '0);
        if (words_due == '0)
          in_block = 1'b0;
        if (kept_words < MAX_WORDS) begin
          res.event_kind = lpwd_pkg::EV_WORD;
          kept_words = kept_words + 1;
        end else begin
          res.event_kind = lpwd_pkg::EV_OVERFLOW;
        end
      end
    end
  endtask

  // present one request, wait for acceptance, record what it should produce
  task automatic send_item(input lpwd_pkg::item_t it, input bit typed,
                           input lpwd_pkg::result_t want);
    bit                fired;
    lpwd_pkg::result_t res;
    if ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    deframe_step(it, fired, res);
    if (typed)
      due_results.push_back(want);
    else if (fired)
      due_results.push_back(res);
    items_sent = items_sent + 1;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(lpwd_pkg::item_t'{lpwd_pkg::CMD_DATA, b}, 1'b0, '0);
  endtask

  task automatic send_close();
    send_item(lpwd_pkg::item_t'{lpwd_pkg::CMD_CLOSE, 8'($urandom)}, 1'b0, '0);
  endtask

  task automatic send_header(input logic [31:0] count);
    send_byte(count[31:24]);
    send_byte(count[23:16]);
    send_byte(count[15:8]);
    send_byte(count[7:0]);
  endtask

  task automatic send_word(input logic [31:0] w);
    send_byte(w[7:0]);
    send_byte(w[15:8]);
    send_byte(w[23:16]);
    send_byte(w[31:24]);
  endtask

  function automatic row_t row(input lpwd_pkg::command_t c, input logic [7:0] b);
    row_t r;
    r.it = '{c, b};
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t row_x(input lpwd_pkg::command_t c, input logic [7:0] b,
                                 input lpwd_pkg::event_kind_t k, input logic [31:0] w,
                                 input logic [lpwd_pkg::INDEX_W-1:0] i, input logic l);
    row_t r;
    r.it = '{c, b};
    r.typed = 1'b1;
    r.want = '{k, w, i, l};
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      mismatches = mismatches + 1;
    end
  endfunction

  // result side: random backpressure and comparison against the oldest expectation
  always @(posedge clk) begin
    lpwd_pkg::result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: expected no result got %h", $time, result);
          mismatches = mismatches + 1;
        end else begin
          want = due_results.pop_front();
          check_field("event_kind", 32'(want.event_kind), 32'(result.event_kind));
          check_field("payload_word", want.payload_word, result.payload_word);
          check_field("word_index", 32'(want.word_index), 32'(result.word_index));
          check_field("block_last", 32'(want.block_last), 32'(result.block_last));
        end
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // random traffic: mostly well-formed blocks, some broken streams and closes
  task automatic random_traffic(input int unsigned goal);
    int unsigned pick;
    int unsigned n;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        n = $urandom_range(1, 6);
        send_header(n);
        repeat (n) send_word($urandom);
      end else if (pick < 75) begin
        send_header(32'd0);
      end else if (pick < 85) begin
        // huge count, a few words, maybe a partial word, then the peer drops
        send_header($urandom | 32'h0000_0100);
        repeat ($urandom_range(1, 3)) send_word($urandom);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
        send_close();
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 7)) send_byte(8'($urandom));
        send_close();
      end else begin
        send_close();
      end
    end
  endtask

  initial begin
    // directed table: extremes, end of transmission, partial groups, closes
    plan.push_back(row_x(lpwd_pkg::CMD_CLOSE, 8'h00, lpwd_pkg::EV_ABORT, 32'd0, 11'd0, 1'b0));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'h00));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'h00));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'h00));
    plan.push_back(row_x(lpwd_pkg::CMD_DATA, 8'h00, lpwd_pkg::EV_END, 32'd0, 11'd0, 1'b0));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'h00));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'h00));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'h00));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'h02));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'hFF));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'hFF));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'hFF));
    plan.push_back(row_x(lpwd_pkg::CMD_DATA, 8'hFF, lpwd_pkg::EV_WORD, 32'hFFFF_FFFF,
                         11'd0, 1'b0));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'h01));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'h02));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'h03));
    plan.push_back(row_x(lpwd_pkg::CMD_DATA, 8'h80, lpwd_pkg::EV_WORD, 32'h8003_0201,
                         11'd1, 1'b1));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'h00));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'h00));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'h00));
    plan.push_back(row_x(lpwd_pkg::CMD_DATA, 8'h00, lpwd_pkg::EV_END, 32'd0, 11'd2, 1'b0));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'hFF));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'hFF));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'hFF));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'hFF));
    plan.push_back(row(lpwd_pkg::CMD_DATA, 8'hAA));
    plan.push_back(row_x(lpwd_pkg::CMD_CLOSE, 8'h55, lpwd_pkg::EV_ABORT, 32'd0, 11'd0, 1'b0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k])
      send_item(plan[k].it, plan[k].typed, plan[k].want);

    // slow receiver, then slow sender, then full rate
    random_traffic(180);
    send_gap_pct = 74;
    recv_stall_pct = 24;
    random_traffic(350);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    random_traffic(500);

    // a clean transmission from a fresh connection, then the peer drops
    send_close();
    send_header(32'd2);
    repeat (2) send_word($urandom);
    send_header(32'd0);
    send_close();

    item_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
